// File: hdl/stbs_pkg.sv
// Shared types and constants for the sorted-table binary search core.
// No dependencies; imported by every module of the block.
package stbs_pkg;

	// Table geometry
	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int DATA_W      = 32;
	localparam int CNT_W       = 5;

	// Stream payload widths (fields packed from bit 0, padded to bytes)
	localparam int IN_FIELDS_W  = IDX_W + 2 * DATA_W;
	localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = 1 + IDX_W;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	// Command queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef enum logic {
		CMD_WRITE  = 1'b0,
		CMD_SEARCH = 1'b1
	} cmd_t;

	// One queued command: value is the entry for a write, the key for a search
	typedef struct packed {
		cmd_t                     cmd;
		logic [IDX_W-1:0]         index;
		logic signed [DATA_W-1:0] value;
	} q_item_t;

	// Queue status seen by the front and back
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

// File: hdl/stbs_queue.sv
// Small FIFO of classified commands between the front and back parts.
// Depends on stbs_pkg.
module stbs_queue
	import stbs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  q_item_t   push_item,
	input  logic      pop,
	output q_item_t   head_item,
	output q_status_t status
);

	q_item_t           q_mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	// Storage, written at the tail
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head_item    = q_mem_q[rd_ptr_q];
	assign status.full  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);

endmodule

// File: hdl/stbs_front.sv
// Front part: takes input transactions, classifies them and queues them.
// Depends on stbs_pkg.
module stbs_front
	import stbs_pkg::*;
(
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_TDATA_W-1:0] s_axis_tdata,
	input  logic                  s_axis_tuser,
	input  q_status_t             q_status,
	output logic                  q_push,
	output q_item_t               q_item
);

	logic [IDX_W-1:0]         entry_index;
	logic signed [DATA_W-1:0] entry_value;
	logic signed [DATA_W-1:0] search_key;

	// Unpack fields
	assign entry_index = s_axis_tdata[IDX_W-1:0];
	assign entry_value = s_axis_tdata[IDX_W +: DATA_W];
	assign search_key  = s_axis_tdata[IDX_W+DATA_W +: DATA_W];

	// Accept whenever the queue has room
	assign s_axis_tready = !q_status.full;
	assign q_push        = s_axis_tvalid && s_axis_tready;

	// Classify: a write carries its entry, a search carries its key
	always_comb begin
		q_item.cmd   = cmd_t'(s_axis_tuser);
		q_item.index = entry_index;
		unique case (cmd_t'(s_axis_tuser))
			CMD_WRITE:  q_item.value = entry_value;
			CMD_SEARCH: q_item.value = search_key;
			default:    q_item.value = search_key;
		endcase
	end

endmodule

// File: hdl/stbs_back.sv
// Back part: table memory, iterative search sequencer and result register.
// Depends on stbs_pkg.
module stbs_back
	import stbs_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	input  logic [CNT_W-1:0]       cfg_data,
	input  q_status_t              q_status,
	input  q_item_t                q_item,
	output logic                   q_pop,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_COMPARE,
		ST_DONE
	} state_t;

	state_t                   state_q;
	logic [CNT_W-1:0]         entry_count_q;
	logic signed [DATA_W-1:0] key_q;
	logic [IDX_W:0]           lo_q;
	logic signed [IDX_W+1:0]  hi_q;
	logic [IDX_W-1:0]         mid_q;
	logic                     hit_q;
	logic [IDX_W-1:0]         where_q;
	logic                     out_valid_q;
	logic                     out_found_q;
	logic [IDX_W-1:0]         out_index_q;

	logic signed [DATA_W-1:0] table_mem [TABLE_DEPTH];
	logic signed [DATA_W-1:0] rdata_q;

	logic [CNT_W-1:0]         count_sat;
	logic signed [IDX_W+1:0]  hi_init;
	logic                     in_range;
	logic [IDX_W+1:0]         mid_sum;
	logic [IDX_W-1:0]         mid;
	logic                     mem_we;
	logic                     mem_re;
	logic                     out_load;

	// Entry count register, saturated to the table depth where it is read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= CNT_W'(TABLE_DEPTH);
		end else if (cfg_valid) begin
			entry_count_q <= cfg_data;
		end
	end

	assign count_sat = (entry_count_q > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
	                                                         : entry_count_q;
	assign hi_init   = $signed((IDX_W+2)'(count_sat)) - (IDX_W+2)'(1);

	// Probe midpoint, rounded down
	assign in_range = $signed({1'b0, lo_q}) <= hi_q;
	assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q[IDX_W:0]};
	assign mid      = mid_sum[IDX_W:1];

	assign q_pop  = (state_q == ST_IDLE) && !q_status.empty;
	assign mem_we = q_pop && (q_item.cmd == CMD_WRITE);
	assign mem_re = (state_q == ST_ISSUE) && in_range;

	// Result register loads when the search is done and the slot is free
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

	// Table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			table_mem[q_item.index] <= q_item.value;
		end
		if (mem_re) begin
			rdata_q <= table_mem[mid];
		end
	end

	// Search sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			key_q       <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			mid_q       <= '0;
			hit_q       <= 1'b0;
			where_q     <= '0;
			out_found_q <= 1'b0;
			out_index_q <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_found_q <= hit_q;
				out_index_q <= where_q;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop && q_item.cmd == CMD_SEARCH) begin
						key_q   <= q_item.value;
						lo_q    <= '0;
						hi_q    <= hi_init;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					if (in_range) begin
						mid_q   <= mid;
						state_q <= ST_COMPARE;
					end else begin
						hit_q   <= 1'b0;
						where_q <= '0;
						state_q <= ST_DONE;
					end
				end
				ST_COMPARE: begin
					if (key_q == rdata_q) begin
						hit_q   <= 1'b1;
						where_q <= mid_q;
						state_q <= ST_DONE;
					end else if (key_q < rdata_q) begin
						hi_q    <= $signed({2'b00, mid_q}) - (IDX_W+2)'(1);
						state_q <= ST_ISSUE;
					end else begin
						lo_q    <= {1'b0, mid_q} + (IDX_W+1)'(1);
						state_q <= ST_ISSUE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}}, out_index_q, out_found_q};

endmodule

// File: hdl/sorted_table_binary_search_core.sv
// Top level of the sorted-table binary search core.
// Depends on stbs_pkg, stbs_front, stbs_queue and stbs_back.
//
// Channel   | Direction | Transaction moves
// ----------+-----------+-----------------------------------------------
// s_axis    | in        | tuser: command; tdata: entry_index, entry_value,
//           |           |   search_key
// m_axis    | out       | tdata: found, match_index (one per search)
// cfg       | in        | data: entry_count
//
// A write goes into the table memory as it is popped. A search makes P probes
// (at most 5 for 16 entries), each one registered read of the table memory and
// one compare; a miss ends with one more range check. The search waits in its
// done state while a result waits in the result register.
// The queue holds four commands, so until it is full input is taken while the
// back part works and while a result waits in the output register.
// arst_n clears control state and sets entry_count to 16; the table is not
// cleared. The cfg channel is always ready.
module sorted_table_binary_search_core
	import stbs_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// [3:0] entry_index, [35:4] entry_value, [67:36] search_key, [71:68] zero
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// [0] command
	input  logic                   s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// [0] found, [4:1] match_index, [7:5] zero
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CNT_W-1:0]       cfg_data
);

	q_status_t q_status;
	q_item_t   push_item;
	q_item_t   head_item;
	logic      q_push;
	logic      q_pop;

	assign cfg_ready = 1'b1;

	// Accept and classify
	stbs_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_status      (q_status),
		.q_push        (q_push),
		.q_item        (push_item)
	);

	// Decoupling queue
	stbs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.pop       (q_pop),
		.head_item (head_item),
		.status    (q_status)
	);

	// Table and search
	stbs_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_data      (cfg_data),
		.q_status      (q_status),
		.q_item        (head_item),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// A miss always reports index zero
	a_miss_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[IDX_W:1] == '0))
		else $error("miss reported with nonzero index");

	// Queue never pushed when full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_status.full)
		else $error("command queue overflow");

	// Queue never popped when empty
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_status.empty)
		else $error("command queue underflow");

endmodule
